@@ rtl/htx_pkg.sv @@
// Shared types, constants and fixed-point helper functions of the transform engine.
package htx_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int FIELD_W    = 32;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int SUM_W      = 2 * DATA_WIDTH + 2;
	localparam int CNT_W      = 4;
	localparam int DRAIN_CYCLES = 2;

	typedef logic signed [DATA_WIDTH-1:0] elem_t;
	typedef elem_t [3:0] row_t;
	typedef row_t [3:0] mat_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef enum logic [2:0] {
		CMD_IDENTITY    = 3'd0,
		CMD_TRANSLATE   = 3'd1,
		CMD_SCALE       = 3'd2,
		CMD_ROTATE      = 3'd3,
		CMD_PERSPECTIVE = 3'd4,
		CMD_LOAD_ROW    = 3'd5,
		CMD_VERTEX      = 3'd6,
		CMD_NOP         = 3'd7
	} cmd_e;

	localparam logic [1:0] AXIS_X   = 2'd0;
	localparam logic [1:0] AXIS_Y   = 2'd1;
	localparam logic [1:0] AXIS_Z   = 2'd2;
	localparam logic [1:0] LAST_ROW = 2'd3;

	localparam sum_t VMAX_W = (sum_t'(1) <<< (DATA_WIDTH - 1)) - sum_t'(1);
	localparam sum_t VMIN_W = -VMAX_W - sum_t'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MUL_DRAIN,
		ST_VTX,
		ST_VTX_DRAIN,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       issue;
		logic       issue_vtx;
		logic [1:0] row;
		logic [1:0] col;
		logic       load_out;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	// Clamp a wide signed value to the element range.
	function automatic elem_t sat_elem(sum_t x);
		elem_t r;
		if (x > VMAX_W) begin
			r = VMAX_W[DATA_WIDTH-1:0];
		end else if (x < VMIN_W) begin
			r = VMIN_W[DATA_WIDTH-1:0];
		end else begin
			r = x[DATA_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic elem_t field_in(logic signed [FIELD_W-1:0] v);
		return sat_elem(sum_t'(v));
	endfunction

	function automatic elem_t neg_sat(elem_t x);
		return sat_elem(-sum_t'(x));
	endfunction

	function automatic elem_t one_val();
		return sat_elem(sum_t'(1) <<< FRAC_BITS);
	endfunction

	function automatic logic signed [FIELD_W-1:0] field_out(elem_t x);
		sum_t w;
		w = sum_t'(x);
		return w[FIELD_W-1:0];
	endfunction

	// Matrix that a set-up command leaves as the current matrix.
	function automatic mat_t setup_matrix(logic [2:0] cmd, logic [1:0] idx,
			elem_t a, elem_t b, elem_t c);
		mat_t m;
		m = '0;
		for (int i = 0; i < 4; i++) begin
			m[i][i] = one_val();
		end
		case (cmd)
			CMD_TRANSLATE: begin
				m[0][3] = a;
				m[1][3] = b;
				m[2][3] = c;
			end
			CMD_SCALE: begin
				m[0][0] = a;
				m[1][1] = b;
				m[2][2] = c;
			end
			CMD_ROTATE: begin
				case (idx)
					AXIS_X: begin
						m[1][1] = a;
						m[2][2] = a;
						m[1][2] = neg_sat(b);
						m[2][1] = b;
					end
					AXIS_Y: begin
						m[0][0] = a;
						m[2][2] = a;
						m[0][2] = b;
						m[2][0] = neg_sat(b);
					end
					AXIS_Z: begin
						m[0][0] = a;
						m[1][1] = a;
						m[0][1] = b;
						m[1][0] = neg_sat(b);
					end
					default: begin
					end
				endcase
			end
			CMD_PERSPECTIVE: begin
				m[0][0] = a;
				m[1][1] = a;
				m[2][2] = '0;
				m[3][3] = '0;
				m[2][3] = neg_sat(one_val());
				m[3][2] = neg_sat(b);
			end
			default: begin
			end
		endcase
		return m;
	endfunction

endpackage

@@ rtl/htx_ctrl.sv @@
// Controller state machine that sequences command acceptance, dot-product issue, drain and result hand-off.
module htx_ctrl import htx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic [1:0] index,
	input  dp_sts_t    sts,
	output ctl_cmd_t   cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             acc;
	logic             mul_last, vtx_last, drain_last;

	assign acc        = (state_q == ST_IDLE) && in_valid;
	assign mul_last   = (cnt_q == CNT_W'(15));
	assign vtx_last   = (cnt_q == CNT_W'(3));
	assign drain_last = (cnt_q == CNT_W'(DRAIN_CYCLES - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (command == CMD_LOAD_ROW && index == LAST_ROW) begin
						state_d = ST_MUL;
					end else if (command == CMD_VERTEX) begin
						state_d = ST_VTX;
					end
				end
			end
			ST_MUL: begin
				if (mul_last) state_d = ST_MUL_DRAIN;
			end
			ST_MUL_DRAIN: begin
				if (drain_last) state_d = ST_IDLE;
			end
			ST_VTX: begin
				if (vtx_last) state_d = ST_VTX_DRAIN;
			end
			ST_VTX_DRAIN: begin
				if (drain_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.accept    = acc;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MUL: begin
				cmd.issue = 1'b1;
				cmd.row   = cnt_q[3:2];
				cmd.col   = cnt_q[1:0];
			end
			ST_VTX: begin
				cmd.issue     = 1'b1;
				cmd.issue_vtx = 1'b1;
				cmd.row       = cnt_q[1:0];
			end
			ST_OUT: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/htx_dp.sv @@
// Datapath: matrix storage, four-lane multiply pipeline, row commit and output register.
module htx_dp import htx_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctl_cmd_t                  cmd,
	output dp_sts_t                   sts,
	input  logic [2:0]                command,
	input  logic [1:0]                index,
	input  logic signed [FIELD_W-1:0] value0,
	input  logic signed [FIELD_W-1:0] value1,
	input  logic signed [FIELD_W-1:0] value2,
	input  logic signed [FIELD_W-1:0] value3,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [FIELD_W-1:0] out_x,
	output logic signed [FIELD_W-1:0] out_y,
	output logic signed [FIELD_W-1:0] out_z,
	output logic signed [FIELD_W-1:0] out_w
);

	mat_t  cur_q, opnd_q;
	row_t  vtx_q, rowbuf_q, vbuf_q, out_q;
	row_t  in_row, sel_row, sel_col;
	logic  out_valid_q;

	prod_t [3:0] prod_s1;
	logic        valid_s1, vtx_s1;
	logic [1:0]  row_s1, col_s1;
	sum_t  [1:0] psum_s2;
	logic        valid_s2, vtx_s2;
	logic [1:0]  row_s2, col_s2;

	sum_t  total, shifted;
	elem_t res;

	assign in_row[0] = field_in(value0);
	assign in_row[1] = field_in(value1);
	assign in_row[2] = field_in(value2);
	assign in_row[3] = field_in(value3);

	// Operand selection: a row of the current matrix against the vertex or an operand column.
	always_comb begin
		sel_row = cur_q[cmd.row];
		for (int k = 0; k < 4; k++) begin
			sel_col[k] = cmd.issue_vtx ? vtx_q[k] : opnd_q[k][cmd.col];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= $signed(sel_row[k]) * $signed(sel_col[k]);
		end
		row_s1     <= cmd.row;
		col_s1     <= cmd.col;
		vtx_s1     <= cmd.issue_vtx;
		psum_s2[0] <= sum_t'(prod_s1[0]) + sum_t'(prod_s1[1]);
		psum_s2[1] <= sum_t'(prod_s1[2]) + sum_t'(prod_s1[3]);
		row_s2     <= row_s1;
		col_s2     <= col_s1;
		vtx_s2     <= vtx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	// Final add, floor shift and clamp.
	assign total   = psum_s2[0] + psum_s2[1];
	assign shifted = total >>> FRAC_BITS;
	assign res     = sat_elem(shifted);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= setup_matrix(CMD_IDENTITY, AXIS_X, '0, '0, '0);
			opnd_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (command == CMD_LOAD_ROW) begin
					opnd_q[index] <= in_row;
				end else if (command == CMD_IDENTITY || command == CMD_TRANSLATE ||
						command == CMD_SCALE || command == CMD_ROTATE ||
						command == CMD_PERSPECTIVE) begin
					cur_q <= setup_matrix(command, index, in_row[0], in_row[1], in_row[2]);
				end
			end
			// A product row is committed only once all four of its columns are done.
			if (valid_s2 && !vtx_s2 && col_s2 == LAST_ROW) begin
				cur_q[row_s2] <= {res, rowbuf_q[2], rowbuf_q[1], rowbuf_q[0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) vtx_q <= in_row;
		if (valid_s2) begin
			if (vtx_s2) begin
				vbuf_q[row_s2] <= res;
			end else begin
				rowbuf_q[col_s2] <= res;
			end
		end
		if (cmd.load_out) out_q <= vbuf_q;
	end

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = field_out(out_q[0]);
	assign out_y     = field_out(out_q[1]);
	assign out_z     = field_out(out_q[2]);
	assign out_w     = field_out(out_q[3]);

endmodule

@@ rtl/homogeneous_transform_engine.sv @@
// Top level of the homogeneous 4x4 transform engine: controller plus datapath.
// Set-up commands and operand rows 0-2 are taken while the controller stays idle; a vertex
// is offered as its result beat after one matrix row per cycle through four multipliers,
// then a two-stage add and clamp; the next command is taken once that beat has reached the
// result register; row 3 starts 16 dot products. The result register lets a new command be
// accepted while a vertex beat waits. Asynchronous active-low reset sets identity and zero.
module homogeneous_transform_engine import htx_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                command,
	input  logic [1:0]                index,
	input  logic signed [FIELD_W-1:0] value0,
	input  logic signed [FIELD_W-1:0] value1,
	input  logic signed [FIELD_W-1:0] value2,
	input  logic signed [FIELD_W-1:0] value3,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [FIELD_W-1:0] out_x,
	output logic signed [FIELD_W-1:0] out_y,
	output logic signed [FIELD_W-1:0] out_z,
	output logic signed [FIELD_W-1:0] out_w
);

	// The controller sequences the work; the datapath holds all matrix state.
	ctl_cmd_t ctl;
	dp_sts_t  sts;

	// The controller accepts one input beat at a time and steps the issue counter
	// over matrix rows (vertex) or row/column pairs (matrix product).
	htx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.index    (index),
		.sts      (sts),
		.cmd      (ctl)
	);

	// The datapath computes one four-term dot product per cycle and writes product
	// rows back only after the whole row is finished, so later columns still see
	// the old row.
	htx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl),
		.sts       (sts),
		.command   (command),
		.index     (index),
		.value0    (value0),
		.value1    (value1),
		.value2    (value2),
		.value3    (value3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w)
	);

endmodule

@@ verif/htx_check_pkg.sv @@
// Scoreboard for the transform engine: predicted matrix state and the queue of expected vertices.
package htx_check_pkg;
	import htx_pkg::*;

	typedef logic signed [FIELD_W-1:0] word_t;

	typedef struct {
		word_t x;
		word_t y;
		word_t z;
		word_t w;
	} vertex_t;

	class vertex_scoreboard;
		// Wide enough for a sum of four full-scale products with room to spare.
		typedef logic signed [2*DATA_WIDTH+3:0] acc_t;

		elem_t   current[4][4];
		elem_t   operand[4][4];
		vertex_t expected_vertices[$];
		int      errors;
		int      vertices_seen;
		int      products_done;
		int      setups_done;

		function new();
			errors = 0;
			vertices_seen = 0;
			products_done = 0;
			setups_done = 0;
			load_identity();
			foreach (operand[i, j]) operand[i][j] = '0;
		endfunction

		function elem_t clamp(acc_t v);
			acc_t top;
			acc_t bottom;
			top = (acc_t'(1) <<< (DATA_WIDTH - 1)) - acc_t'(1);
			bottom = -top - acc_t'(1);
			if (v > top) return top[DATA_WIDTH-1:0];
			if (v < bottom) return bottom[DATA_WIDTH-1:0];
			return v[DATA_WIDTH-1:0];
		endfunction

		function elem_t unity();
			return clamp(acc_t'(1) <<< FRAC_BITS);
		endfunction

		function elem_t negate(elem_t x);
			return clamp(-acc_t'(x));
		endfunction

		// Exact sum of four products, floored by the fraction shift, then clamped.
		function elem_t row_dot(elem_t r[4], elem_t c[4]);
			acc_t s;
			s = '0;
			for (int k = 0; k < 4; k++) s += acc_t'(r[k]) * acc_t'(c[k]);
			return clamp(s >>> FRAC_BITS);
		endfunction

		function void load_identity();
			foreach (current[i, j]) current[i][j] = (i == j) ? unity() : elem_t'(0);
		endfunction

		function void note_command(logic [2:0] cmd, logic [1:0] idx,
				word_t a0, word_t a1, word_t a2, word_t a3);
			elem_t   v[4];
			elem_t   col[4];
			elem_t   prod[4][4];
			vertex_t want;
			v[0] = clamp(acc_t'(a0));
			v[1] = clamp(acc_t'(a1));
			v[2] = clamp(acc_t'(a2));
			v[3] = clamp(acc_t'(a3));
			if (cmd <= CMD_PERSPECTIVE) begin
				load_identity();
				setups_done++;
			end
			case (cmd)
				CMD_TRANSLATE: begin
					current[0][3] = v[0];
					current[1][3] = v[1];
					current[2][3] = v[2];
				end
				CMD_SCALE: begin
					current[0][0] = v[0];
					current[1][1] = v[1];
					current[2][2] = v[2];
				end
				CMD_ROTATE: begin
					if (idx == AXIS_X) begin
						current[1][1] = v[0];
						current[2][2] = v[0];
						current[1][2] = negate(v[1]);
						current[2][1] = v[1];
					end else if (idx == AXIS_Y) begin
						current[0][0] = v[0];
						current[2][2] = v[0];
						current[0][2] = v[1];
						current[2][0] = negate(v[1]);
					end else if (idx == AXIS_Z) begin
						current[0][0] = v[0];
						current[1][1] = v[0];
						current[0][1] = v[1];
						current[1][0] = negate(v[1]);
					end
				end
				CMD_PERSPECTIVE: begin
					current[0][0] = v[0];
					current[1][1] = v[0];
					current[2][2] = '0;
					current[3][3] = '0;
					current[2][3] = negate(unity());
					current[3][2] = negate(v[1]);
				end
				CMD_LOAD_ROW: begin
					for (int k = 0; k < 4; k++) operand[idx][k] = v[k];
					if (idx == LAST_ROW) begin
						for (int j = 0; j < 4; j++) begin
							for (int k = 0; k < 4; k++) col[k] = operand[k][j];
							for (int i = 0; i < 4; i++) prod[i][j] = row_dot(current[i], col);
						end
						current = prod;
						products_done++;
					end
				end
				CMD_VERTEX: begin
					want.x = word_t'(row_dot(current[0], v));
					want.y = word_t'(row_dot(current[1], v));
					want.z = word_t'(row_dot(current[2], v));
					want.w = word_t'(row_dot(current[3], v));
					expected_vertices.push_back(want);
				end
				default: begin
				end
			endcase
		endfunction

		function void compare_field(string name, word_t want, word_t got);
			if (want !== got) begin
				$error("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
					name, want, want, got, got);
				errors++;
			end
		endfunction

		function void check_vertex(word_t x, word_t y, word_t z, word_t w);
			vertex_t want;
			if (expected_vertices.size() == 0) begin
				$error("vertex beat with nothing outstanding: x=%0d y=%0d z=%0d w=%0d",
					x, y, z, w);
				errors++;
				return;
			end
			want = expected_vertices.pop_front();
			vertices_seen++;
			compare_field("out_x", want.x, x);
			compare_field("out_y", want.y, y);
			compare_field("out_z", want.z, z);
			compare_field("out_w", want.w, w);
		endfunction

		function int pending();
			return expected_vertices.size();
		endfunction
	endclass

endpackage

@@ verif/homogeneous_transform_engine_tb.sv @@
// Self-checking testbench of the homogeneous transform engine with random flow control.
module homogeneous_transform_engine_tb;
	import htx_pkg::*;
	import htx_check_pkg::*;

	// Handy Q16.16 corner values.
	localparam word_t W_MAX  = 32'sh7FFF_FFFF;
	localparam word_t W_MIN  = 32'sh8000_0000;
	localparam word_t Q_ONE  = 32'sh0001_0000;
	localparam word_t Q_NEG1 = -32'sh0001_0000;
	localparam int    BEAT_TARGET = 600;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	logic  [2:0] command = CMD_NOP;
	logic  [1:0] index = '0;
	word_t value0 = '0;
	word_t value1 = '0;
	word_t value2 = '0;
	word_t value3 = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t out_x;
	word_t out_y;
	word_t out_z;
	word_t out_w;

	vertex_scoreboard sb;
	int beats_sent = 0;
	bit sender_steady = 1'b0;
	bit held_off = 1'b0;

	homogeneous_transform_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.index(index),
		.value0(value0),
		.value1(value1),
		.value2(value2),
		.value3(value3),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.out_w(out_w)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle length for either side: mostly none, often a few cycles, now and then a long gap.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Operand values: mostly small Q16.16 numbers so that products stay in range,
	// some corner values to hit saturation, and some fully random words.
	function automatic word_t rand_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return word_t'($urandom_range(0, 6 << 16)) - (3 << 16);
		if (r < 80) begin
			case ($urandom_range(0, 5))
				0: return W_MAX;
				1: return W_MIN;
				2: return '0;
				3: return -32'sd1;
				4: return Q_ONE;
				default: return Q_NEG1;
			endcase
		end
		return word_t'($urandom());
	endfunction

	// One input beat. Valid is held with a steady payload until the engine takes it;
	// the prediction is updated at the edge where the handshake completes.
	task automatic send_beat(cmd_e cmd, logic [1:0] idx,
			word_t a0, word_t a1, word_t a2, word_t a3);
		int gap;
		gap = sender_steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		index    <= idx;
		value0   <= a0;
		value1   <= a1;
		value2   <= a2;
		value3   <= a3;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_command(cmd, idx, a0, a1, a2, a3);
		if (cmd != CMD_NOP) beats_sent++;
	endtask

	// A vertex with random coordinates; w is usually 1.0 as in ordinary geometry.
	task automatic send_vertex();
		word_t w;
		w = ($urandom_range(0, 9) < 7) ? Q_ONE : rand_word();
		send_beat(CMD_VERTEX, 2'($urandom_range(0, 3)), rand_word(), rand_word(),
			rand_word(), w);
	endtask

	// A complete operand matrix: rows 0 to 2 in shuffled order, then the last row,
	// which fires the matrix product.
	task automatic load_operand_set();
		logic [1:0] order[3];
		logic [1:0] t;
		int         s;
		order[0] = 2'd0;
		order[1] = 2'd1;
		order[2] = 2'd2;
		for (int k = 2; k > 0; k--) begin
			s = $urandom_range(0, k);
			t = order[k];
			order[k] = order[s];
			order[s] = t;
		end
		for (int k = 0; k < 3; k++) begin
			send_beat(CMD_LOAD_ROW, order[k], rand_word(), rand_word(), rand_word(),
				rand_word());
		end
		send_beat(CMD_LOAD_ROW, LAST_ROW, rand_word(), rand_word(), rand_word(),
			rand_word());
	endtask

	// Every output beat is checked at the edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_vertex(out_x, out_y, out_z, out_w);
		end
	end

	// Receiver: random ready stretches and stalls. Once, after a few dozen vertices have
	// come back, ready is held low for a long stretch so the result path backs up and
	// the engine has to refuse input while the sender keeps offering vertices.
	initial begin
		int run;
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && sb.vertices_seen >= 40) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (250) @(posedge clk);
			end
			out_ready <= 1'b1;
			run = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(20, 60);
			repeat (run) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Main sequence: reset, directed corner cases, random traffic, drain and verdict.
	initial begin
		int pick;
		int drain;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Vertices through the reset identity, including full-scale coordinates.
		send_beat(CMD_VERTEX, 2'd0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE);
		send_beat(CMD_VERTEX, 2'd3, W_MAX, W_MIN, '0, -32'sd1);
		// Translate by extreme offsets; the sums saturate on both sides.
		send_beat(CMD_TRANSLATE, 2'd2, W_MAX, W_MIN, -32'sd1, W_MAX);
		send_beat(CMD_VERTEX, 2'd1, Q_ONE, Q_ONE, Q_ONE, W_MAX);
		// Non-uniform scale with extremes, then a uniform one.
		send_beat(CMD_SCALE, 2'd1, W_MIN, W_MAX, 2 * Q_ONE, W_MIN);
		send_beat(CMD_VERTEX, 2'd0, W_MIN, W_MIN, W_MAX, Q_ONE);
		send_beat(CMD_SCALE, 2'd0, 3 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE, '0);
		send_beat(CMD_VERTEX, 2'd2, Q_NEG1, 5 * Q_ONE, -32'sd7, Q_ONE);
		// Rotation about x with the most negative sine, whose negation saturates.
		send_beat(CMD_ROTATE, AXIS_X, W_MIN, W_MIN, W_MAX, W_MAX);
		send_beat(CMD_VERTEX, 2'd0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
		// Rotations about y and z with a 0.6 / 0.8 cosine-sine pair.
		send_beat(CMD_ROTATE, AXIS_Y, 32'sh0000_9999, 32'sh0000_CCCC, '0, '0);
		send_beat(CMD_VERTEX, 2'd3, 2 * Q_ONE, Q_NEG1, 4 * Q_ONE, Q_ONE);
		send_beat(CMD_ROTATE, AXIS_Z, 32'sh0000_9999, -32'sh0000_CCCC, '0, '0);
		send_beat(CMD_VERTEX, 2'd1, 2 * Q_ONE, Q_NEG1, 4 * Q_ONE, Q_ONE);
		// Rotation with no axis leaves the identity.
		send_beat(CMD_ROTATE, LAST_ROW, W_MIN, W_MAX, -32'sd1, -32'sd1);
		send_beat(CMD_VERTEX, 2'd2, 7 * Q_ONE, -32'sd3, W_MAX, Q_ONE);
		// Perspective with the most negative near plane.
		send_beat(CMD_PERSPECTIVE, 2'd3, 2 * Q_ONE, W_MIN, W_MAX, W_MIN);
		send_beat(CMD_VERTEX, 2'd0, Q_ONE, 2 * Q_ONE, Q_NEG1, Q_ONE);
		// Full operand load and product, then the last row alone over stale rows.
		load_operand_set();
		send_vertex();
		send_beat(CMD_LOAD_ROW, LAST_ROW, W_MAX, W_MIN, Q_ONE, '0);
		send_vertex();
		// The unused command changes nothing.
		send_beat(CMD_NOP, 2'd3, W_MIN, W_MAX, -32'sd1, -32'sd1);
		send_vertex();
		send_beat(CMD_IDENTITY, 2'd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
		send_vertex();

		// Random traffic. Most of it is vertices and complete operand sets over fresh
		// set-up matrices; lone row writes and the unused command are the noise.
		while (beats_sent < BEAT_TARGET) begin
			if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_vertex();
			end else if (pick < 62) begin
				send_beat(cmd_e'($urandom_range(0, 4)), 2'($urandom_range(0, 3)),
					rand_word(), rand_word(), rand_word(), rand_word());
			end else if (pick < 77) begin
				load_operand_set();
				repeat ($urandom_range(1, 3)) send_vertex();
			end else if (pick < 92) begin
				send_beat(CMD_LOAD_ROW, 2'($urandom_range(0, 3)), rand_word(),
					rand_word(), rand_word(), rand_word());
			end else if (pick < 96) begin
				send_beat(CMD_NOP, 2'($urandom_range(0, 3)), word_t'($urandom()),
					word_t'($urandom()), word_t'($urandom()), word_t'($urandom()));
			end else begin
				send_beat(CMD_VERTEX, 2'($urandom_range(0, 3)), word_t'($urandom()),
					word_t'($urandom()), word_t'($urandom()), word_t'($urandom()));
			end
		end
		in_valid <= 1'b0;

		// Drain: wait for the outstanding vertices, bounded, then a few more cycles so a
		// stray extra beat would still be caught.
		drain = 0;
		while (sb.pending() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (40) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected vertex results never arrived", sb.pending());
			sb.errors += sb.pending();
		end

		$display("Run covered %0d input beats: %0d vertices checked, %0d matrix set-ups,",
			beats_sent, sb.vertices_seen, sb.setups_done);
		$display("%0d operand products, long output hold-off %s.", sb.products_done,
			held_off ? "applied" : "not reached");
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#6000000;
		$display("FAIL");
		$finish;
	end

endmodule

@@ homogeneous_transform_engine.f @@
rtl/htx_pkg.sv
rtl/htx_ctrl.sv
rtl/htx_dp.sv
rtl/homogeneous_transform_engine.sv
verif/htx_check_pkg.sv
verif/homogeneous_transform_engine_tb.sv
